// ----- sv/p11sof_pkg.sv -----
`timescale 1ns / 1ps
// Package for the PDP-11 source operand fetch block.
// Holds the beat types for both channels and the shared codes; no dependencies.
package p11sof_pkg;

    // Request codes of the input beat
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_DATA  = 2'd1;
    localparam logic [1:0] REQ_LOAD  = 2'd2;

    // Result kinds
    localparam logic RES_READ = 1'b0;
    localparam logic RES_DONE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_STACK_LIMIT = 1'b0;
    localparam logic CFG_STACK_CHECK = 1'b1;

    // Addressing modes
    localparam logic [2:0] MODE_REG       = 3'd0;
    localparam logic [2:0] MODE_DEF       = 3'd1;
    localparam logic [2:0] MODE_AINC      = 3'd2;
    localparam logic [2:0] MODE_AINC_DEF  = 3'd3;
    localparam logic [2:0] MODE_ADEC      = 3'd4;
    localparam logic [2:0] MODE_ADEC_DEF  = 3'd5;
    localparam logic [2:0] MODE_INDEX     = 3'd6;
    localparam logic [2:0] MODE_INDEX_DEF = 3'd7;

    localparam logic [2:0] SP_NUM = 3'd6;
    localparam logic [2:0] PC_NUM = 3'd7;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  addr_mode;
        logic [2:0]  reg_num;
        logic        byte_op;
        logic [15:0] data_word;
    } src_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] mem_addr;
        logic        mem_byte;
        logic [15:0] operand_value;
        logic [15:0] eff_addr;
        logic        stack_fault;
    } src_result_t;

endpackage

// ----- sv/pdp11_source_operand_fetch.sv -----
`timescale 1ns / 1ps
// PDP-11 source operand fetch: register file, fetch sequencer and result register.
// Depends on p11sof_pkg for beat types and codes.
//
// A beat is first taken into the input register and is processed from there;
// its result (if any) is then written to the output register.
// Throughput: one beat per cycle, limited only by the output handshake.
// Reset (rst_n, async, active low) clears registers R0-R7, the fetch phase,
// the pending operand state, both configuration registers and both valid flags.
module pdp11_source_operand_fetch
    import p11sof_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  src_item_t   in_data,

    output logic        out_valid,
    input  logic        out_ready,
    output src_result_t out_data,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    // Fetch phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_INDEX = 2'd1;  // waiting for the index word
    localparam logic [1:0] PH_PTR   = 2'd2;  // waiting for the pointer word
    localparam logic [1:0] PH_OPND  = 2'd3;  // waiting for the operand

    // Input register
    logic        in_valid_reg;
    src_item_t   in_data_reg;

    // Output register
    logic        out_valid_reg;
    src_result_t out_data_reg;
    logic        out_valid_next;

    // Architectural and sequencer state
    logic [15:0] rf_reg [8];
    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  pmode_reg, pmode_next;
    logic [2:0]  preg_reg, preg_next;
    logic        pbyte_reg, pbyte_next;
    logic [15:0] paddr_reg, paddr_next;
    logic        fault_reg, fault_next;

    // Configuration
    logic [15:0] stack_limit_reg;
    logic        stack_check_reg;

    // Processing of the registered beat
    logic        has_result;
    logic        fire;
    logic        rf_we;
    logic [2:0]  rf_waddr;
    logic [15:0] rf_wdata;
    logic [2:0]  rd_addr;
    logic [15:0] rd_val;
    logic [15:0] pc_val;
    logic [15:0] step;
    logic [15:0] inc_val;
    logic [15:0] dec_val;
    logic [15:0] idx_sum;
    logic        sp_low;
    src_result_t res;

    src_item_t   it;
    assign it = in_data_reg;

    // Only a start while idle or read data while busy produces a result.
    always_comb
    begin
        has_result = 1'b0;
        if (it.req_type == REQ_START)
        begin
            has_result = (phase_reg == PH_IDLE);
        end
        else if (it.req_type == REQ_DATA)
        begin
            has_result = (phase_reg != PH_IDLE);
        end
    end

    // A beat without a result never waits on the output side.
    assign fire     = in_valid_reg && (!has_result || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    // One shared read port: the index add reads the pending register, all
    // else reads the register named in the beat. PC has a fixed tap.
    assign rd_addr = (it.req_type == REQ_DATA) ? preg_reg : it.reg_num;
    assign rd_val  = rf_reg[rd_addr];
    assign pc_val  = rf_reg[PC_NUM];

    // Byte autoinc/autodec steps by 1 except on SP and PC.
    assign step    = (it.byte_op && (it.reg_num < SP_NUM)) ? 16'd1 : 16'd2;
    assign inc_val = rd_val + step;
    assign dec_val = rd_val - step;
    assign idx_sum = rd_val + it.data_word;
    assign sp_low  = (it.reg_num == SP_NUM) && stack_check_reg && (dec_val < stack_limit_reg);

    always_comb
    begin
        phase_next = phase_reg;
        pmode_next = pmode_reg;
        preg_next  = preg_reg;
        pbyte_next = pbyte_reg;
        paddr_next = paddr_reg;
        fault_next = fault_reg;
        rf_we      = 1'b0;
        rf_waddr   = it.reg_num;
        rf_wdata   = it.data_word;
        res        = '0;

        unique case (it.req_type)
            REQ_LOAD:
            begin
                rf_we = 1'b1;
            end
            REQ_START:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    pmode_next = it.addr_mode;
                    preg_next  = it.reg_num;
                    pbyte_next = it.byte_op;
                    fault_next = 1'b0;
                    res.result_kind = RES_READ;
                    case (it.addr_mode)
                        MODE_REG:
                        begin
                            // register mode: operand straight from the file
                            res.result_kind   = RES_DONE;
                            res.operand_value = it.byte_op ? {8'h00, rd_val[7:0]} : rd_val;
                        end
                        MODE_DEF:
                        begin
                            paddr_next   = rd_val;
                            phase_next   = PH_OPND;
                            res.mem_addr = rd_val;
                            res.mem_byte = it.byte_op;
                        end
                        MODE_AINC:
                        begin
                            paddr_next   = rd_val;
                            rf_we        = 1'b1;
                            rf_wdata     = inc_val;
                            phase_next   = PH_OPND;
                            res.mem_addr = rd_val;
                            res.mem_byte = it.byte_op;
                        end
                        MODE_AINC_DEF:
                        begin
                            // step is always 2 here: deferred pointer is a word
                            rf_we        = 1'b1;
                            rf_wdata     = rd_val + 16'd2;
                            phase_next   = PH_PTR;
                            res.mem_addr = rd_val;
                        end
                        MODE_ADEC:
                        begin
                            rf_we        = 1'b1;
                            rf_wdata     = dec_val;
                            fault_next   = sp_low;
                            paddr_next   = dec_val;
                            phase_next   = PH_OPND;
                            res.mem_addr = dec_val;
                            res.mem_byte = it.byte_op;
                        end
                        MODE_ADEC_DEF:
                        begin
                            // word step; SP check still applies
                            rf_we        = 1'b1;
                            rf_wdata     = rd_val - 16'd2;
                            fault_next   = (it.reg_num == SP_NUM) && stack_check_reg
                                           && ((rd_val - 16'd2) < stack_limit_reg);
                            phase_next   = PH_PTR;
                            res.mem_addr = rd_val - 16'd2;
                        end
                        default:
                        begin
                            // index modes: fetch index word at PC
                            rf_we        = 1'b1;
                            rf_waddr     = PC_NUM;
                            rf_wdata     = pc_val + 16'd2;
                            phase_next   = PH_INDEX;
                            res.mem_addr = pc_val;
                        end
                    endcase
                end
            end
            REQ_DATA:
            begin
                res.result_kind = RES_READ;
                case (phase_reg)
                    PH_INDEX:
                    begin
                        res.mem_addr = idx_sum;
                        if (pmode_reg == MODE_INDEX)
                        begin
                            paddr_next   = idx_sum;
                            phase_next   = PH_OPND;
                            res.mem_byte = pbyte_reg;
                        end
                        else
                        begin
                            phase_next = PH_PTR;
                        end
                    end
                    PH_PTR:
                    begin
                        paddr_next   = it.data_word;
                        phase_next   = PH_OPND;
                        res.mem_addr = it.data_word;
                        res.mem_byte = pbyte_reg;
                    end
                    PH_OPND:
                    begin
                        phase_next        = PH_IDLE;
                        res.result_kind   = RES_DONE;
                        res.operand_value = pbyte_reg ? {8'h00, it.data_word[7:0]}
                                                      : it.data_word;
                        res.eff_addr      = paddr_reg;
                        res.stack_fault   = fault_reg;
                    end
                    default:
                    begin
                        res = '0;
                    end
                endcase
            end
            default:
            begin
                // unused request code: dropped
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire && has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_IDLE;
            pmode_reg       <= '0;
            preg_reg        <= '0;
            pbyte_reg       <= 1'b0;
            paddr_reg       <= '0;
            fault_reg       <= 1'b0;
            stack_limit_reg <= '0;
            stack_check_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                rf_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                phase_reg <= phase_next;
                pmode_reg <= pmode_next;
                preg_reg  <= preg_next;
                pbyte_reg <= pbyte_next;
                paddr_reg <= paddr_next;
                fault_reg <= fault_next;
                if (rf_we)
                begin
                    rf_reg[rf_waddr] <= rf_wdata;
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_STACK_LIMIT)
                begin
                    stack_limit_reg <= cfg_data;
                end
                else
                begin
                    stack_check_reg <= cfg_data[0];
                end
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
        if (fire && has_result)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
